// File: rtl/rlbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlbr_pkg
// Shared types, constants and the sine table of the radial light blob renderer.
// ----------------------------------------------------------------------------
package rlbr_pkg;

    localparam int MAX_LIGHTS_DEF = 16;
    localparam int MAX_DIM        = 64;
    localparam int FIFO_DEPTH     = 4;
    localparam int CFG_IDX_W      = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PANEL_ROWS  = 3'd0,
        REG_PANEL_COLS  = 3'd1,
        REG_LIGHT_COUNT = 3'd2,
        REG_RADIUS      = 3'd3,
        REG_COL_MIN     = 3'd4,
        REG_COL_MAX     = 3'd5,
        REG_ROW_MIN     = 3'd6,
        REG_ROW_MAX     = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_RENDER  = 2'd1,
        OP_ADVANCE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_RENDER  = 2'd1,
        CMD_ADVANCE = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [3:0]         light_index;
        logic [7:0]         load_red;
        logic [7:0]         load_green;
        logic [7:0]         load_blue;
        logic signed [15:0] load_row_pos;
        logic signed [15:0] load_col_pos;
        logic [8:0]         load_heading;
        logic [6:0]         load_speed;
        logic [5:0]         pixel_row;
        logic [5:0]         pixel_col;
    } in_item_t;

    typedef struct packed {
        logic [11:0] pixel_index;
        logic [7:0]  chan_first;
        logic [7:0]  chan_second;
        logic [7:0]  chan_third;
    } out_item_t;

    typedef struct packed {
        logic [6:0]        panel_rows;
        logic [6:0]        panel_cols;
        logic [4:0]        light_count;
        logic [7:0]        falloff_radius;
        logic signed [7:0] col_min;
        logic signed [7:0] col_max;
        logic signed [7:0] row_min;
        logic signed [7:0] row_max;
    } cfg_t;

    typedef struct packed {
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic signed [15:0] row;
        logic signed [15:0] col;
        logic [8:0]         heading;
        logic [6:0]         speed;
    } light_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [3:0]  idx;
        light_t      light;
        logic [5:0]  pixel_row;
        logic [5:0]  pixel_col;
        logic [11:0] pixel_index;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef struct packed {
        logic       neg;
        logic [6:0] mag;
    } sine_t;

    // round(100 * sin(a)) for a = 0..90 degrees.
    localparam logic [6:0] SIN_Q [0:90] = '{
        7'd0, 7'd2, 7'd3, 7'd5, 7'd7, 7'd9, 7'd10, 7'd12, 7'd14, 7'd16,
        7'd17, 7'd19, 7'd21, 7'd22, 7'd24, 7'd26, 7'd28, 7'd29, 7'd31, 7'd33,
        7'd34, 7'd36, 7'd37, 7'd39, 7'd41, 7'd42, 7'd44, 7'd45, 7'd47, 7'd48,
        7'd50, 7'd52, 7'd53, 7'd54, 7'd56, 7'd57, 7'd59, 7'd60, 7'd62, 7'd63,
        7'd64, 7'd66, 7'd67, 7'd68, 7'd69, 7'd71, 7'd72, 7'd73, 7'd74, 7'd75,
        7'd77, 7'd78, 7'd79, 7'd80, 7'd81, 7'd82, 7'd83, 7'd84, 7'd85, 7'd86,
        7'd87, 7'd87, 7'd88, 7'd89, 7'd90, 7'd91, 7'd91, 7'd92, 7'd93, 7'd93,
        7'd94, 7'd95, 7'd95, 7'd96, 7'd96, 7'd97, 7'd97, 7'd97, 7'd98, 7'd98,
        7'd98, 7'd99, 7'd99, 7'd99, 7'd99, 7'd100, 7'd100, 7'd100, 7'd100,
        7'd100, 7'd100
    };

    // Sign and magnitude of round(100 * sin(h)) for h in 0..359.
    function automatic sine_t sine_of(input logic [8:0] h);
        logic [8:0] a;
        sine_t      s;
        if (h <= 9'd90) begin
            a = h;
            s.neg = 1'b0;
        end else if (h <= 9'd180) begin
            a = 9'd180 - h;
            s.neg = 1'b0;
        end else if (h <= 9'd270) begin
            a = h - 9'd180;
            s.neg = 1'b1;
        end else begin
            a = 9'd360 - h;
            s.neg = 1'b1;
        end
        s.mag = SIN_Q[a[6:0]];
        return s;
    endfunction

endpackage

// File: rtl/rlbr_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlbr_fifo
// Short command queue between the classifying front end and the back end.
// ----------------------------------------------------------------------------
module rlbr_fifo (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  rlbr_pkg::cmd_t         push_data,
    input  logic                   pop,
    output rlbr_pkg::cmd_t         head,
    output rlbr_pkg::fifo_stat_t   stat
);
    localparam int PTR_W = $clog2(rlbr_pkg::FIFO_DEPTH);

    rlbr_pkg::cmd_t   slot_reg [rlbr_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign head       = slot_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == (PTR_W+1)'(rlbr_pkg::FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

// File: rtl/rlbr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlbr_front
// Decodes incoming beats, drops those with no effect and prepares commands.
// ----------------------------------------------------------------------------
module rlbr_front #(
    parameter int MAX_LIGHTS = rlbr_pkg::MAX_LIGHTS_DEF
) (
    input  rlbr_pkg::in_item_t item,
    input  rlbr_pkg::cfg_t     cfg,
    output logic               keep,
    output rlbr_pkg::cmd_t     cmd
);
    logic [6:0]  rows_eff, cols_eff;
    logic        on_panel;
    logic [12:0] index_full;

    always_comb begin
        rows_eff = (32'(cfg.panel_rows) > rlbr_pkg::MAX_DIM) ?
                   7'(rlbr_pkg::MAX_DIM) : cfg.panel_rows;
        cols_eff = (32'(cfg.panel_cols) > rlbr_pkg::MAX_DIM) ?
                   7'(rlbr_pkg::MAX_DIM) : cfg.panel_cols;
        on_panel = (7'(item.pixel_row) < rows_eff) && (7'(item.pixel_col) < cols_eff);
        // Strip runs serpentine-free but mirrored along each row.
        index_full = 13'(item.pixel_row) * 13'(cols_eff) + 13'(cols_eff)
                   - 13'd1 - 13'(item.pixel_col);

        cmd.idx           = item.light_index;
        cmd.light.red     = item.load_red;
        cmd.light.green   = item.load_green;
        cmd.light.blue    = item.load_blue;
        cmd.light.row     = item.load_row_pos;
        cmd.light.col     = item.load_col_pos;
        cmd.light.heading = (item.load_heading >= 9'd360) ?
                            item.load_heading - 9'd360 : item.load_heading;
        cmd.light.speed   = item.load_speed;
        cmd.pixel_row     = item.pixel_row;
        cmd.pixel_col     = item.pixel_col;
        cmd.pixel_index   = index_full[11:0];

        unique case (rlbr_pkg::op_t'(item.op))
            rlbr_pkg::OP_LOAD: begin
                cmd.kind = rlbr_pkg::CMD_LOAD;
                keep     = (32'(item.light_index) < MAX_LIGHTS);
            end
            rlbr_pkg::OP_RENDER: begin
                cmd.kind = rlbr_pkg::CMD_RENDER;
                keep     = on_panel && (cfg.light_count != 5'd0);
            end
            rlbr_pkg::OP_ADVANCE: begin
                cmd.kind = rlbr_pkg::CMD_ADVANCE;
                keep     = 1'b1;
            end
            rlbr_pkg::OP_NONE: begin
                cmd.kind = rlbr_pkg::CMD_ADVANCE;
                keep     = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/rlbr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlbr_back
// Executes commands: light table writes, per-light render walk, light motion.
// ----------------------------------------------------------------------------
module rlbr_back #(
    parameter int MAX_LIGHTS = rlbr_pkg::MAX_LIGHTS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rlbr_pkg::cfg_t        cfg,
    input  logic                  cmd_empty,
    input  rlbr_pkg::cmd_t        cmd,
    output logic                  cmd_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rlbr_pkg::out_item_t   m_data,
    output logic                  busy
);
    localparam int IDX_W = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
    localparam int CNT_W = $clog2(MAX_LIGHTS + 1);
    localparam int ACC_W = 16 + CNT_W;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_FETCH   = 11'b000_0000_0010,
        S_SQ      = 11'b000_0000_0100,
        S_SUM     = 11'b000_0000_1000,
        S_ROOT    = 11'b000_0001_0000,
        S_MUL     = 11'b000_0010_0000,
        S_DIV     = 11'b000_0100_0000,
        S_ACC     = 11'b000_1000_0000,
        S_OUT     = 11'b001_0000_0000,
        S_ADV_MUL = 11'b010_0000_0000,
        S_ADV_WB  = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Light table.
    rlbr_pkg::light_t mem [MAX_LIGHTS];
    rlbr_pkg::light_t rd_reg;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    rlbr_pkg::light_t wr_data;

    // Walk control.
    logic [CNT_W-1:0] cnt_reg, n_eff;
    logic             is_adv_reg;
    logic [3:0]       step_reg;
    logic [5:0]       pr_reg, pc_reg;
    logic [11:0]      pix_reg;

    // Render datapath.
    logic [31:0]      sq_r_reg, sq_c_reg, x_reg;
    logic [17:0]      rem_reg;
    logic [15:0]      root_reg;
    logic             hit_reg;
    logic [14:0]      drem_reg [3];
    logic [15:0]      dlow_reg [3];
    logic [15:0]      q_reg [3];
    logic [ACC_W-1:0] acc_reg [3];

    // Motion datapath.
    logic [26:0]      qr_reg, qc_reg;
    logic             neg_r_reg, neg_c_reg;

    rlbr_pkg::out_item_t m_data_reg;
    logic                m_valid_reg;

    // Combinational helpers.
    logic [17:0]        pr100, pc100;
    logic signed [17:0] dr, dc;
    logic [15:0]        adr, adc;
    logic [19:0]        rt, rtrial;
    logic [14:0]        r100;
    logic [14:0]        w;
    logic               hit;
    logic [7:0]         color [3];
    logic [22:0]        prod [3];
    logic [15:0]        dt [3];
    logic [9:0]         hc10;
    rlbr_pkg::sine_t    sr, sc;
    logic [13:0]        mr, mc;
    logic signed [17:0] step_r, step_c, rpos, cpos;
    logic signed [17:0] cmin, cmax, rmin, rmax;
    logic signed [10:0] hs;
    rlbr_pkg::light_t   moved;
    logic               last;

    assign n_eff = (32'(cfg.light_count) > MAX_LIGHTS) ?
                   CNT_W'(MAX_LIGHTS) : CNT_W'(cfg.light_count);
    assign last  = ((cnt_reg + 1'b1) == n_eff);
    assign r100  = 15'(cfg.falloff_radius) * 15'd100;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[cnt_reg[IDX_W-1:0]];
    end

    always_comb begin
        // Render: distance to the light in hundredths of a cell.
        pr100 = 18'(pr_reg) * 18'd100;
        pc100 = 18'(pc_reg) * 18'd100;
        dr    = $signed(pr100) - 18'(rd_reg.row);
        dc    = $signed(pc100) - 18'(rd_reg.col);
        adr   = dr[17] ? 16'(-dr) : 16'(dr);
        adc   = dc[17] ? 16'(-dc) : 16'(dc);
        rt     = {rem_reg, x_reg[31:30]};
        rtrial = {2'b00, root_reg, 2'b01};
        hit   = (r100 != 15'd0) && (root_reg < 16'(r100));
        w     = r100 - root_reg[14:0];
        color[0] = rd_reg.red;
        color[1] = rd_reg.green;
        color[2] = rd_reg.blue;
        for (int c = 0; c < 3; c++) begin
            prod[c] = 23'(color[c]) * 23'(w);
            dt[c]   = {drem_reg[c], dlow_reg[c][15]};
        end

        // Motion: sine lookups and rounded step magnitudes.
        hc10 = 10'(rd_reg.heading) + 10'd90;
        if (hc10 >= 10'd360) begin
            hc10 = hc10 - 10'd360;
        end
        sr = rlbr_pkg::sine_of(rd_reg.heading);
        sc = rlbr_pkg::sine_of(hc10[8:0]);
        mr = 14'(sr.mag) * 14'(rd_reg.speed) + 14'd50;
        mc = 14'(sc.mag) * 14'(rd_reg.speed) + 14'd50;

        // floor(m / 100) as (m * 5243) >> 19, exact for m below 10100.
        step_r = neg_r_reg ? -18'(qr_reg[26:19]) : 18'(qr_reg[26:19]);
        step_c = neg_c_reg ? -18'(qc_reg[26:19]) : 18'(qc_reg[26:19]);
        rpos = 18'(rd_reg.row) + step_r;
        cpos = 18'(rd_reg.col) + step_c;
        cmin = 18'(cfg.col_min) * 18'sd100;
        cmax = 18'(cfg.col_max) * 18'sd100;
        rmin = 18'(cfg.row_min) * 18'sd100;
        rmax = 18'(cfg.row_max) * 18'sd100;
        hs   = 11'(rd_reg.heading);
        if (cpos > cmax) begin
            cpos = cmax;
            hs = (hs < 11'sd90) ? 11'sd180 - hs : 11'sd540 - hs;
        end
        if (cpos < cmin) begin
            cpos = cmin;
            hs = (hs > 11'sd180) ? 11'sd540 - hs : 11'sd180 - hs;
        end
        if (rpos > rmax) begin
            rpos = rmax;
            hs = (hs < 11'sd270) ? 11'sd540 - hs : 11'sd360 - hs;
        end
        if (rpos < rmin) begin
            rpos = rmin;
            hs = 11'sd360 - hs;
        end
        if (hs < 11'sd0) begin
            hs = hs + 11'sd360;
        end
        if (hs >= 11'sd360) begin
            hs = hs - 11'sd360;
        end
        moved         = rd_reg;
        moved.row     = rpos[15:0];
        moved.col     = cpos[15:0];
        moved.heading = hs[8:0];
    end

    always_comb begin
        state_next = state_reg;
        cmd_pop    = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = cnt_reg[IDX_W-1:0];
        wr_data    = moved;
        unique case (state_reg)
            S_IDLE: begin
                if (!cmd_empty) begin
                    cmd_pop = 1'b1;
                    case (cmd.kind)
                        rlbr_pkg::CMD_LOAD: begin
                            wr_en   = 1'b1;
                            wr_addr = IDX_W'(cmd.idx);
                            wr_data = cmd.light;
                        end
                        rlbr_pkg::CMD_RENDER: state_next = S_FETCH;
                        rlbr_pkg::CMD_ADVANCE: begin
                            if (n_eff != '0) begin
                                state_next = S_FETCH;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_FETCH:   state_next = is_adv_reg ? S_ADV_MUL : S_SQ;
            S_SQ:      state_next = S_SUM;
            S_SUM:     state_next = S_ROOT;
            S_ROOT:    state_next = (step_reg == 4'd15) ? S_MUL : S_ROOT;
            S_MUL:     state_next = S_DIV;
            S_DIV:     state_next = (step_reg == 4'd15) ? S_ACC : S_DIV;
            S_ACC:     state_next = last ? S_OUT : S_FETCH;
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            S_ADV_MUL: state_next = S_ADV_WB;
            S_ADV_WB: begin
                wr_en      = 1'b1;
                state_next = last ? S_IDLE : S_FETCH;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                cnt_reg    <= '0;
                is_adv_reg <= (cmd.kind == rlbr_pkg::CMD_ADVANCE);
                pr_reg     <= cmd.pixel_row;
                pc_reg     <= cmd.pixel_col;
                pix_reg    <= cmd.pixel_index;
                for (int c = 0; c < 3; c++) begin
                    acc_reg[c] <= '0;
                end
            end
            S_SQ: begin
                sq_r_reg <= 32'(adr) * 32'(adr);
                sq_c_reg <= 32'(adc) * 32'(adc);
            end
            S_SUM: begin
                x_reg    <= sq_r_reg + sq_c_reg;
                rem_reg  <= '0;
                root_reg <= '0;
                step_reg <= '0;
            end
            S_ROOT: begin
                // One result bit per cycle of the integer square root.
                if (rt >= rtrial) begin
                    rem_reg  <= 18'(rt - rtrial);
                    root_reg <= {root_reg[14:0], 1'b1};
                end else begin
                    rem_reg  <= rt[17:0];
                    root_reg <= {root_reg[14:0], 1'b0};
                end
                x_reg    <= {x_reg[29:0], 2'b00};
                step_reg <= step_reg + 4'd1;
            end
            S_MUL: begin
                hit_reg  <= hit;
                step_reg <= '0;
                for (int c = 0; c < 3; c++) begin
                    drem_reg[c] <= prod[c][22:8];
                    dlow_reg[c] <= {prod[c][7:0], 8'h00};
                    q_reg[c]    <= '0;
                end
            end
            S_DIV: begin
                // Restoring division by the radius, one quotient bit a cycle.
                for (int c = 0; c < 3; c++) begin
                    if (dt[c] >= 16'(r100)) begin
                        drem_reg[c] <= 15'(dt[c] - 16'(r100));
                        q_reg[c]    <= {q_reg[c][14:0], 1'b1};
                    end else begin
                        drem_reg[c] <= dt[c][14:0];
                        q_reg[c]    <= {q_reg[c][14:0], 1'b0};
                    end
                    dlow_reg[c] <= {dlow_reg[c][14:0], 1'b0};
                end
                step_reg <= step_reg + 4'd1;
            end
            S_ACC: begin
                for (int c = 0; c < 3; c++) begin
                    if (hit_reg) begin
                        acc_reg[c] <= acc_reg[c] + ACC_W'(q_reg[c]);
                    end
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
            S_ADV_MUL: begin
                neg_r_reg <= ~sr.neg;
                neg_c_reg <= sc.neg;
                qr_reg    <= 27'(mr) * 27'd5243;
                qc_reg    <= 27'(mc) * 27'd5243;
            end
            S_ADV_WB: begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_OUT && (!m_valid_reg || m_ready)) begin
            m_data_reg.pixel_index <= pix_reg;
            m_data_reg.chan_first  <= (acc_reg[1][ACC_W-1:8] > (ACC_W-8)'(255)) ?
                                      8'hFF : acc_reg[1][15:8];
            m_data_reg.chan_second <= (acc_reg[0][ACC_W-1:8] > (ACC_W-8)'(255)) ?
                                      8'hFF : acc_reg[0][15:8];
            m_data_reg.chan_third  <= (acc_reg[2][ACC_W-1:8] > (ACC_W-8)'(255)) ?
                                      8'hFF : acc_reg[2][15:8];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign busy    = (state_reg != S_IDLE);

endmodule

// File: rtl/radial_light_blob_renderer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_light_blob_renderer
// Light table with per-pixel radial falloff rendering and bouncing motion.
// ----------------------------------------------------------------------------
// A front end classifies each input beat (load a light, render a pixel,
// advance all lights) and drops beats that have no effect: unused op codes,
// loads beyond the table, pixels off the panel and renders with no lights in
// use. Kept beats wait in a four-entry command queue while the back end works
// through them one at a time. A load is written into the table from the idle
// state. A render walks the lights in use and takes each light through a table
// read, squaring, summing, a bit-serial square root, the color products, a
// restoring division run side by side for the three color channels and the
// accumulate; the square root and divider loops take most of a render. An
// advance reads each light, computes its move and writes it back in place.
// Results leave through an output register, so the next beats are accepted
// while a pixel waits to be taken. There is no clearing pass after reset:
// lights read before they are loaded return whatever the table holds.
module radial_light_blob_renderer #(
    parameter int MAX_LIGHTS = rlbr_pkg::MAX_LIGHTS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  rlbr_pkg::in_item_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output rlbr_pkg::out_item_t               m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rlbr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [7:0]                        cfg_data
);
    rlbr_pkg::cfg_t       cfg_reg;
    rlbr_pkg::cmd_t       front_cmd, queue_head;
    rlbr_pkg::fifo_stat_t queue_stat;
    logic                 keep, push, pop, back_busy;

    // Config regs always writable; user must write while idle, unenforced.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.panel_rows     <= 7'd12;
            cfg_reg.panel_cols     <= 7'd16;
            cfg_reg.light_count    <= 5'd0;
            cfg_reg.falloff_radius <= 8'd13;
            cfg_reg.col_min        <= -8'sd3;
            cfg_reg.col_max        <= 8'sd16;
            cfg_reg.row_min        <= -8'sd3;
            cfg_reg.row_max        <= 8'sd12;
        end else if (cfg_valid) begin
            unique case (rlbr_pkg::cfg_reg_t'(cfg_index))
                rlbr_pkg::REG_PANEL_ROWS:  cfg_reg.panel_rows     <= cfg_data[6:0];
                rlbr_pkg::REG_PANEL_COLS:  cfg_reg.panel_cols     <= cfg_data[6:0];
                rlbr_pkg::REG_LIGHT_COUNT: cfg_reg.light_count    <= cfg_data[4:0];
                rlbr_pkg::REG_RADIUS:      cfg_reg.falloff_radius <= cfg_data;
                rlbr_pkg::REG_COL_MIN:     cfg_reg.col_min        <= cfg_data;
                rlbr_pkg::REG_COL_MAX:     cfg_reg.col_max        <= cfg_data;
                rlbr_pkg::REG_ROW_MIN:     cfg_reg.row_min        <= cfg_data;
                rlbr_pkg::REG_ROW_MAX:     cfg_reg.row_max        <= cfg_data;
            endcase
        end
    end

    // An input beat is taken whenever the queue has room; dropped beats
    // are simply consumed.
    assign s_ready = !queue_stat.full;
    assign push    = s_valid && s_ready && keep;

    rlbr_front #(
        .MAX_LIGHTS (MAX_LIGHTS)
    ) u_front (
        .item (s_data),
        .cfg  (cfg_reg),
        .keep (keep),
        .cmd  (front_cmd)
    );

    rlbr_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (front_cmd),
        .pop       (pop),
        .head      (queue_head),
        .stat      (queue_stat)
    );

    rlbr_back #(
        .MAX_LIGHTS (MAX_LIGHTS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd_empty (queue_stat.empty),
        .cmd       (queue_head),
        .cmd_pop   (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .busy      (back_busy)
    );

    // The queue is never written when full nor read when empty.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && queue_stat.full))
        else $error("command queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && queue_stat.empty))
        else $error("command queue read while empty");

    // A new result only follows a render walk in the back end.
    a_result_from_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(back_busy))
        else $error("result beat without a render in progress");

endmodule

// File: bench/radial_light_blob_renderer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_light_blob_renderer_tb
// Self-checking bench: a scoreboard class predicts every rendered pixel from
// its own copy of the light table and registers, while plain tasks drive
// load, render and advance beats under several idling patterns.
// ----------------------------------------------------------------------------
module radial_light_blob_renderer_tb;
    import rlbr_pkg::*;

    // Cycles with no accepted beat on any channel before the run is abandoned.
    localparam int STALL_LIMIT  = 20000;
    // Quiet time after the last pixel so queued advances finish before a
    // register write (four queued advances over sixteen lights fit easily).
    localparam int SETTLE_CYCLES = 1000;
    localparam int HOLD_CYCLES   = 3000;

    // The scoreboard owns the predicted light table and register copy. An
    // accepted input beat updates that state and may queue one pixel.
    class blob_scoreboard;
        cfg_t      regs;
        light_t    lights [16];
        out_item_t pixels_due [$];
        int        sin_q [0:90] = '{
            0, 2, 3, 5, 7, 9, 10, 12, 14, 16, 17, 19, 21, 22, 24, 26, 28, 29,
            31, 33, 34, 36, 37, 39, 41, 42, 44, 45, 47, 48, 50, 52, 53, 54, 56,
            57, 59, 60, 62, 63, 64, 66, 67, 68, 69, 71, 72, 73, 74, 75, 77, 78,
            79, 80, 81, 82, 83, 84, 85, 86, 87, 87, 88, 89, 90, 91, 91, 92, 93,
            93, 94, 95, 95, 96, 96, 97, 97, 97, 98, 98, 98, 99, 99, 99, 99,
            100, 100, 100, 100, 100, 100};

        function new();
            regs.panel_rows     = 7'd12;
            regs.panel_cols     = 7'd16;
            regs.light_count    = 5'd0;
            regs.falloff_radius = 8'd13;
            regs.col_min        = -8'sd3;
            regs.col_max        = 8'sd16;
            regs.row_min        = -8'sd3;
            regs.row_max        = 8'sd12;
            foreach (lights[i]) lights[i] = '0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [7:0] v);
            case (idx)
                REG_PANEL_ROWS:  regs.panel_rows     = v[6:0];
                REG_PANEL_COLS:  regs.panel_cols     = v[6:0];
                REG_LIGHT_COUNT: regs.light_count    = v[4:0];
                REG_RADIUS:      regs.falloff_radius = v;
                REG_COL_MIN:     regs.col_min        = v;
                REG_COL_MAX:     regs.col_max        = v;
                REG_ROW_MIN:     regs.row_min        = v;
                REG_ROW_MAX:     regs.row_max        = v;
                default: ;
            endcase
        endfunction

        function int dim(int v);
            return (v > MAX_DIM) ? MAX_DIM : v;
        endfunction

        function int lights_active();
            return (regs.light_count > 16) ? 16 : int'(regs.light_count);
        endfunction

        // Hundredths of sin(h) with the quadrant folded onto the table.
        function int sin100(int h);
            h = h % 360;
            if (h <= 90)  return sin_q[h];
            if (h <= 180) return sin_q[180 - h];
            if (h <= 270) return -sin_q[h - 180];
            return -sin_q[360 - h];
        endfunction

        // Step length rounded half away from zero.
        function int move_by(int s, int spd);
            int m;
            m = ((s < 0 ? -s : s) * spd + 50) / 100;
            return (s < 0) ? -m : m;
        endfunction

        function longint unsigned floor_root(longint unsigned x);
            longint unsigned r, t;
            r = 0;
            for (int b = 24; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if (t * t <= x) r = t;
            end
            return r;
        endfunction

        function void note_input(in_item_t it);
            int rows, cols, n, r100;
            longint dr, dc, d, w, acc_r, acc_g, acc_b;
            int h, rr, cc, cmin, cmax, rmin, rmax, pidx;
            out_item_t px;
            n = lights_active();
            case (op_t'(it.op))
                OP_LOAD: begin
                    lights[it.light_index].red     = it.load_red;
                    lights[it.light_index].green   = it.load_green;
                    lights[it.light_index].blue    = it.load_blue;
                    lights[it.light_index].row     = it.load_row_pos;
                    lights[it.light_index].col     = it.load_col_pos;
                    lights[it.light_index].heading = 9'(int'(it.load_heading) % 360);
                    lights[it.light_index].speed   = it.load_speed;
                end
                OP_RENDER: begin
                    rows = dim(regs.panel_rows);
                    cols = dim(regs.panel_cols);
                    r100 = int'(regs.falloff_radius) * 100;
                    if (it.pixel_row < rows && it.pixel_col < cols && n != 0) begin
                        acc_r = 0; acc_g = 0; acc_b = 0;
                        for (int i = 0; i < n; i++) begin
                            dr = longint'(it.pixel_row) * 100 - longint'($signed(lights[i].row));
                            dc = longint'(it.pixel_col) * 100 - longint'($signed(lights[i].col));
                            d  = longint'(floor_root(dr * dr + dc * dc));
                            if (r100 != 0 && d < r100) begin
                                w = r100 - d;
                                acc_r += (longint'(lights[i].red) * w * 256) / r100;
                                acc_g += (longint'(lights[i].green) * w * 256) / r100;
                                acc_b += (longint'(lights[i].blue) * w * 256) / r100;
                            end
                        end
                        pidx = int'(it.pixel_row) * cols + (cols - 1 - int'(it.pixel_col));
                        px.pixel_index = pidx[11:0];
                        px.chan_first  = ((acc_g >> 8) > 255) ? 8'd255 : 8'(acc_g >> 8);
                        px.chan_second = ((acc_r >> 8) > 255) ? 8'd255 : 8'(acc_r >> 8);
                        px.chan_third  = ((acc_b >> 8) > 255) ? 8'd255 : 8'(acc_b >> 8);
                        pixels_due.push_back(px);
                    end
                end
                OP_ADVANCE: begin
                    cmin = int'(regs.col_min) * 100;
                    cmax = int'(regs.col_max) * 100;
                    rmin = int'(regs.row_min) * 100;
                    rmax = int'(regs.row_max) * 100;
                    for (int i = 0; i < n; i++) begin
                        h  = int'(lights[i].heading) % 360;
                        rr = int'($signed(lights[i].row)) +
                             move_by(-sin100(h), lights[i].speed);
                        cc = int'($signed(lights[i].col)) +
                             move_by(sin100(h + 90), lights[i].speed);
                        if (cc > cmax) begin
                            cc = cmax;
                            h = (h < 90) ? 180 - h : 540 - h;
                        end
                        if (cc < cmin) begin
                            cc = cmin;
                            h = (h > 180) ? 540 - h : 180 - h;
                        end
                        if (rr > rmax) begin
                            rr = rmax;
                            h = (h < 270) ? 540 - h : 360 - h;
                        end
                        if (rr < rmin) begin
                            rr = rmin;
                            h = 360 - h;
                        end
                        h = h % 360;
                        if (h < 0) h += 360;
                        lights[i].row     = rr[15:0];
                        lights[i].col     = cc[15:0];
                        lights[i].heading = h[8:0];
                    end
                end
                default: ;
            endcase
        endfunction

        // Returns 1 when the pixel matches the oldest prediction.
        function bit check_pixel(out_item_t got, output string msg);
            out_item_t exp_px;
            msg = "";
            if (pixels_due.size() == 0) begin
                msg = $sformatf("unexpected pixel %0d", got.pixel_index);
                return 0;
            end
            exp_px = pixels_due.pop_front();
            if (got.pixel_index != exp_px.pixel_index)
                msg = {msg, $sformatf(" index %0d/%0d", got.pixel_index, exp_px.pixel_index)};
            if (got.chan_first != exp_px.chan_first)
                msg = {msg, $sformatf(" green %0d/%0d", got.chan_first, exp_px.chan_first)};
            if (got.chan_second != exp_px.chan_second)
                msg = {msg, $sformatf(" red %0d/%0d", got.chan_second, exp_px.chan_second)};
            if (got.chan_third != exp_px.chan_third)
                msg = {msg, $sformatf(" blue %0d/%0d", got.chan_third, exp_px.chan_third)};
            return msg == "";
        endfunction

        function int pixels_waiting();
            return pixels_due.size();
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [7:0]            cfg_data = '0;

    blob_scoreboard sb = new();
    int  errors = 0;
    int  quiet_cycles = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  recv_hold = 1'b0;

    always #2 aclk = ~aclk;

    radial_light_blob_renderer dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t:%s", $time, msg);
        errors++;
    endtask

    // Sampling happens at the rising edge, before the block's own updates land.
    // A pixel beat is checked before the input beat of the same edge is noted.
    always @(posedge aclk) begin
        string msg;
        if (aresetn) begin
            if (m_valid && m_ready)
                if (!sb.check_pixel(m_data, msg)) report_mismatch(msg);
            if (s_valid && s_ready) sb.note_input(s_data);
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
        end
    end

    // Watchdog: any accepted beat on any channel restarts the count.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("radial_light_blob_renderer test failed");
            $finish;
        end
    end

    // The receiver decides its ready for the next edge at each falling edge.
    always @(negedge aclk) begin
        m_ready = recv_hold ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
    end

    // Offer one input beat, idling first as the current phase asks. Valid is
    // left high afterward, so back-to-back beats never drop it.
    task automatic send_item(in_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_data  = it;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [7:0] v);
        cfg_index = idx;
        cfg_data  = v;
        cfg_valid = 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Wait for every predicted pixel, then let queued advances drain.
    task automatic settle();
        s_valid = 1'b0;
        while (sb.pixels_waiting() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic in_item_t load_item(int idx, int r, int g, int b, int row, int col,
                                           int hd, int spd);
        in_item_t it;
        it = '0;
        it.op = OP_LOAD;
        it.light_index = idx[3:0];
        it.load_red = r[7:0];
        it.load_green = g[7:0];
        it.load_blue = b[7:0];
        it.load_row_pos = row[15:0];
        it.load_col_pos = col[15:0];
        it.load_heading = hd[8:0];
        it.load_speed = spd[6:0];
        return it;
    endfunction

    function automatic in_item_t pixel_item(op_t op, int pr, int pc);
        in_item_t it;
        it = '0;
        it.op = op;
        it.pixel_row = pr[5:0];
        it.pixel_col = pc[5:0];
        return it;
    endfunction

    // A random beat: every field is filled at random so each bit toggles, then
    // the op and the meaningful fields are steered toward useful values.
    function automatic in_item_t random_item();
        in_item_t it;
        int pick, rows, cols;
        it = $bits(in_item_t)'({$urandom, $urandom, $urandom});
        rows = sb.dim(sb.regs.panel_rows);
        cols = sb.dim(sb.regs.panel_cols);
        pick = $urandom_range(99);
        if (pick < 20) it.op = OP_LOAD;
        else if (pick < 80) it.op = OP_RENDER;
        else if (pick < 95) it.op = OP_ADVANCE;
        else it.op = OP_NONE;
        if ($urandom_range(99) < 85 && rows > 0 && cols > 0) begin
            it.pixel_row = 6'($urandom_range(rows - 1));
            it.pixel_col = 6'($urandom_range(cols - 1));
        end
        if ($urandom_range(99) < 80) begin
            it.load_row_pos = 16'($urandom_range(rows * 100 + 600) - 300);
            it.load_col_pos = 16'($urandom_range(cols * 100 + 600) - 300);
        end
        if ($urandom_range(99) < 80) it.load_heading = 9'($urandom_range(359));
        if ($urandom_range(99) < 80) it.load_speed = 7'($urandom_range(100));
        return it;
    endfunction

    initial begin
        int n_items, count;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed part. Every table entry is loaded first so no render or
        // advance ever touches an unwritten light.
        send_item(load_item(0, 255, 255, 255, 32767, -32768, 511, 127));
        send_item(load_item(1, 255, 255, 255, 0, 0, 359, 0));
        send_item(load_item(2, 255, 128, 0, 0, 0, 0, 100));
        for (int i = 3; i < 16; i++)
            send_item(load_item(i, $urandom_range(255), $urandom_range(255),
                                $urandom_range(255), -32768 + i, 32767 - i, 360 + i, i));
        settle();
        write_reg(REG_LIGHT_COUNT, 8'd3);
        write_reg(REG_RADIUS, 8'd255);
        // A white light and an orange light on the same pixel push the red and green sums past 255.
        send_item(pixel_item(OP_RENDER, 0, 0));
        send_item(pixel_item(OP_RENDER, 11, 15));
        // Pixels off the panel and the unused op give nothing.
        send_item(pixel_item(OP_RENDER, 63, 63));
        send_item(pixel_item(OP_RENDER, 12, 0));
        send_item(pixel_item(OP_NONE, 0, 0));
        send_item(pixel_item(OP_ADVANCE, 0, 0));
        send_item(pixel_item(OP_RENDER, 5, 5));
        settle();
        // With no light in use a render gives no pixel.
        write_reg(REG_LIGHT_COUNT, 8'd0);
        send_item(pixel_item(OP_RENDER, 1, 1));
        settle();

        // Random phases; each sets the registers while the block is idle.
        for (int k = 0; k < 8; k++) begin
            case (k % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            case (k)
                0: begin write_reg(REG_PANEL_ROWS, 8'd64); write_reg(REG_PANEL_COLS, 8'd64); end
                1: begin write_reg(REG_PANEL_ROWS, 8'd1);  write_reg(REG_PANEL_COLS, 8'd1);  end
                2: begin write_reg(REG_PANEL_ROWS, 8'd127); write_reg(REG_PANEL_COLS, 8'd0); end
                3: begin write_reg(REG_PANEL_ROWS, 8'd0);  write_reg(REG_PANEL_COLS, 8'd255); end
                default: begin
                    write_reg(REG_PANEL_ROWS, 8'($urandom_range(1, 64)));
                    write_reg(REG_PANEL_COLS, 8'($urandom_range(1, 64)));
                end
            endcase
            case (k)
                2: write_reg(REG_RADIUS, 8'd0);
                4: write_reg(REG_RADIUS, 8'd255);
                5: write_reg(REG_RADIUS, 8'd1);
                default: write_reg(REG_RADIUS, 8'($urandom_range(3, 40)));
            endcase
            // Render time grows with the lights in use, so most phases keep
            // the count small and two phases run the full table, one of them through the clamp.
            count = (k == 6) ? 31 : (k == 7) ? 16 : $urandom_range(1, 4);
            write_reg(REG_LIGHT_COUNT, 8'(count));
            if (k == 5) begin
                // Crossed bounds: each minimum sits above its maximum.
                write_reg(REG_COL_MIN, 8'sd20);
                write_reg(REG_COL_MAX, -8'sd20);
                write_reg(REG_ROW_MIN, 8'sd127);
                write_reg(REG_ROW_MAX, -8'sd128);
            end else if (k == 3) begin
                write_reg(REG_COL_MIN, -8'sd128);
                write_reg(REG_COL_MAX, 8'sd127);
                write_reg(REG_ROW_MIN, 8'($urandom));
                write_reg(REG_ROW_MAX, 8'($urandom));
            end else begin
                write_reg(REG_COL_MIN, 8'(-$urandom_range(0, 5)));
                write_reg(REG_COL_MAX, 8'($urandom_range(1, 20)));
                write_reg(REG_ROW_MIN, 8'(-$urandom_range(0, 5)));
                write_reg(REG_ROW_MAX, 8'($urandom_range(1, 20)));
            end
            // In the first phase the receiver holds off for a long stretch
            // while beats keep coming, so the command queue fills.
            if (k == 0)
                fork
                    begin
                        recv_hold = 1'b1;
                        repeat (HOLD_CYCLES) @(negedge aclk);
                        recv_hold = 1'b0;
                    end
                join_none
            n_items = (k >= 6) ? 40 : 215;
            for (int j = 0; j < n_items; j++) send_item(random_item());
            settle();
        end

        if (errors == 0 && sb.pixels_waiting() == 0)
            $display("radial_light_blob_renderer test passed");
        else
            $display("radial_light_blob_renderer test failed");
        $finish;
    end

endmodule
